@@ sv/bmpg_pkg.sv @@
// Shared types, constants and fixed-point tables for the positive Gaussian sample generator.
package bmpg_pkg;

  localparam int unsigned UNIFORM_BITS  = 32;
  localparam int unsigned LOG_FRAC_BITS = 24;
  localparam int unsigned NORM_STEPS    = 5;
  localparam int unsigned ROOT_BITS     = 27;
  localparam int unsigned SERIES_TERMS  = 5;

  // Register stages of the radius path: normalize, log, subtract, scale, root.
  localparam int unsigned RAD_LAT       = NORM_STEPS + LOG_FRAC_BITS + 2 + ROOT_BITS;
  // Prep, angle, square, two stages per series term, sine product, quadrant map.
  localparam int unsigned TRIG_CORE_LAT = 5 + 2 * SERIES_TERMS;
  localparam int unsigned SCALE_LAT     = 4;
  localparam int unsigned PIPE_DEPTH    = RAD_LAT + SCALE_LAT;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // Series divisors for k = 5 down to 1 become exact reciprocal multiplies.
  // For a 30-bit dividend, ceil(2^(30+l)/d) with l = clog2(d) gives the exact floor.
  localparam int unsigned SIN_SH [SERIES_TERMS] = '{37, 37, 36, 35, 33};
  localparam int unsigned COS_SH [SERIES_TERMS] = '{37, 36, 35, 34, 31};
  localparam logic [63:0] SIN_RECIP [SERIES_TERMS] = '{
    ((64'd1 << 37) + 64'd109) / 64'd110,
    ((64'd1 << 37) + 64'd71)  / 64'd72,
    ((64'd1 << 36) + 64'd41)  / 64'd42,
    ((64'd1 << 35) + 64'd19)  / 64'd20,
    ((64'd1 << 33) + 64'd5)   / 64'd6
  };
  localparam logic [63:0] COS_RECIP [SERIES_TERMS] = '{
    ((64'd1 << 37) + 64'd89) / 64'd90,
    ((64'd1 << 36) + 64'd55) / 64'd56,
    ((64'd1 << 35) + 64'd29) / 64'd30,
    ((64'd1 << 34) + 64'd11) / 64'd12,
    ((64'd1 << 31) + 64'd1)  / 64'd2
  };

  typedef enum logic [1:0] {
    REG_MEAN  = 2'd0,
    REG_SIGMA = 2'd1,
    REG_MIN   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
  } in_item_t;

  typedef struct packed {
    logic [30:0] sample;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [30:0] cmag;
    logic        cneg;
    logic [30:0] smag;
    logic        sneg;
  } trig_t;

  typedef struct packed {
    logic        keep_y;
    logic [30:0] y;
    logic        keep_x;
    logic [30:0] x;
  } pair_t;

endpackage

@@ sv/bmpg_radius.sv @@
// Radius pipeline: normalize, log2 by repeated squaring, scale by 2 ln 2, bit-serial square root.
module bmpg_radius (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] radius_i,
  output logic [26:0] root_o
);

  localparam int unsigned DROP = 32 - bmpg_pkg::UNIFORM_BITS;
  localparam int unsigned NS   = bmpg_pkg::NORM_STEPS;
  localparam int unsigned LS   = bmpg_pkg::LOG_FRAC_BITS;
  localparam int unsigned RB   = bmpg_pkg::ROOT_BITS;
  localparam logic [29:0] UB_Q = 30'(bmpg_pkg::UNIFORM_BITS << bmpg_pkg::LOG_FRAC_BITS);

  logic [31:0] u_raw, u_fix;

  logic [31:0] nm_in [NS];
  logic [4:0]  np_in [NS];
  logic [31:0] nm_d  [NS];
  logic [4:0]  np_d  [NS];
  logic [31:0] nm_q  [NS];
  logic [4:0]  np_q  [NS];

  logic [31:0] lm_in [LS];
  logic [23:0] lf_in [LS];
  logic [4:0]  lp_in [LS];
  logic [63:0] sq    [LS];
  logic [32:0] m2    [LS];
  logic [31:0] lm_d  [LS];
  logic [23:0] lf_d  [LS];
  logic [31:0] lm_q  [LS];
  logic [23:0] lf_q  [LS];
  logic [4:0]  lp_q  [LS];

  logic [29:0] l_d, l_q;
  logic [60:0] r2_prod;
  logic [29:0] r2_q;

  logic [53:0] rem_in [RB];
  logic [26:0] rt_in  [RB];
  logic [55:0] trial  [RB];
  logic [53:0] rem_d  [RB];
  logic [26:0] rt_d   [RB];
  logic [53:0] rem_q  [RB];
  logic [26:0] rt_q   [RB];

  // A zero word is taken as one LSB so the log stays finite.
  assign u_raw = radius_i >> DROP;
  assign u_fix = (u_raw == 32'd0) ? 32'd1 : u_raw;

  // Leading-one normalization, 16/8/4/2/1 shifts.
  always_comb begin
    nm_in[0] = u_fix;
    np_in[0] = 5'd31;
    for (int i = 1; i < NS; i++) begin
      nm_in[i] = nm_q[i-1];
      np_in[i] = np_q[i-1];
    end
    for (int i = 0; i < NS; i++) begin
      if ((nm_in[i] >> (32 - (16 >> i))) == 32'd0) begin
        nm_d[i] = nm_in[i] << (16 >> i);
        np_d[i] = np_in[i] - 5'(16 >> i);
      end else begin
        nm_d[i] = nm_in[i];
        np_d[i] = np_in[i];
      end
    end
  end

  // One fraction bit of log2 per stage.
  always_comb begin
    lm_in[0] = nm_q[NS-1];
    lf_in[0] = '0;
    lp_in[0] = np_q[NS-1];
    for (int i = 1; i < LS; i++) begin
      lm_in[i] = lm_q[i-1];
      lf_in[i] = lf_q[i-1];
      lp_in[i] = lp_q[i-1];
    end
    for (int i = 0; i < LS; i++) begin
      sq[i] = lm_in[i] * lm_in[i];
      m2[i] = sq[i][63:31];
      if (m2[i][32]) begin
        lm_d[i] = m2[i][32:1];
        lf_d[i] = {lf_in[i][22:0], 1'b1};
      end else begin
        lm_d[i] = m2[i][31:0];
        lf_d[i] = {lf_in[i][22:0], 1'b0};
      end
    end
  end

  assign l_d     = UB_Q - 30'({lp_q[LS-1], lf_q[LS-1]});
  assign r2_prod = l_q * bmpg_pkg::TWO_LN2_Q30;

  // Restoring square root, one root bit per stage, most significant first.
  always_comb begin
    rem_in[0] = {r2_q, 24'd0};
    rt_in[0]  = '0;
    for (int j = 1; j < RB; j++) begin
      rem_in[j] = rem_q[j-1];
      rt_in[j]  = rt_q[j-1];
    end
    for (int j = 0; j < RB; j++) begin
      trial[j] = (56'(rt_in[j]) << (RB - j)) + (56'd1 << (2 * (RB - 1 - j)));
      if (56'(rem_in[j]) >= trial[j]) begin
        rem_d[j] = 54'(56'(rem_in[j]) - trial[j]);
        rt_d[j]  = rt_in[j] | (27'd1 << (RB - 1 - j));
      end else begin
        rem_d[j] = rem_in[j];
        rt_d[j]  = rt_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NS; i++) begin
        nm_q[i] <= nm_d[i];
        np_q[i] <= np_d[i];
      end
      for (int i = 0; i < LS; i++) begin
        lm_q[i] <= lm_d[i];
        lf_q[i] <= lf_d[i];
        lp_q[i] <= lp_in[i];
      end
      l_q  <= l_d;
      r2_q <= r2_prod[59:30];
      for (int j = 0; j < RB; j++) begin
        rem_q[j] <= rem_d[j];
        rt_q[j]  <= rt_d[j];
      end
    end
  end

  assign root_o = rt_q[RB-1];

endmodule

@@ sv/bmpg_trig.sv @@
// Angle pipeline: octant folding, Taylor series for sine and cosine, quadrant map, alignment delay.
module bmpg_trig (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     angle_i,
  output bmpg_pkg::trig_t trig_o
);

  localparam int unsigned DROP = 32 - bmpg_pkg::UNIFORM_BITS;
  localparam logic [32:0] LOW  = (33'd1 << DROP) - 33'd1;
  localparam logic [31:0] PH_MASK = ~LOW[31:0];
  localparam int unsigned NT  = bmpg_pkg::SERIES_TERMS;
  // The quadrant-map register is the first entry of the delay line.
  localparam int unsigned DLY = bmpg_pkg::RAD_LAT - bmpg_pkg::TRIG_CORE_LAT + 1;

  logic [31:0] ph;
  logic [29:0] f, g;
  logic        swap;
  logic [1:0]  pq_q;
  logic        psw_q;
  logic [29:0] pg_q;

  logic [61:0] x_prod;
  logic [29:0] x_q;
  logic [1:0]  xq_q;
  logic        xsw_q;

  logic [59:0] x2_prod;
  logic [29:0] x2_q, x2x_q;
  logic [1:0]  x2q_q;
  logic        x2sw_q;

  logic [29:0] si_x2 [NT];
  logic [29:0] si_x  [NT];
  logic [30:0] si_ts [NT];
  logic [30:0] si_tc [NT];
  logic [1:0]  si_q  [NT];
  logic        si_sw [NT];
  logic [60:0] mps   [NT];
  logic [60:0] mpc   [NT];

  logic [29:0] ms_q  [NT];
  logic [29:0] mc_q  [NT];
  logic [29:0] mx2_q [NT];
  logic [29:0] mx_q  [NT];
  logic [1:0]  mq_q  [NT];
  logic        msw_q [NT];

  logic [60:0] qs    [NT];
  logic [60:0] qc    [NT];
  logic [60:0] qs_sh [NT];
  logic [60:0] qc_sh [NT];

  logic [30:0] ts_q  [NT];
  logic [30:0] tc_q  [NT];
  logic [29:0] dx2_q [NT];
  logic [29:0] dx_q  [NT];
  logic [1:0]  dq_q  [NT];
  logic        dsw_q [NT];

  logic [60:0] sn_prod;
  logic [30:0] sn, sn_sel, cs_sel;
  logic [30:0] fs_q, fc_q;
  logic [1:0]  fq_q;

  bmpg_pkg::trig_t quad_d;
  bmpg_pkg::trig_t dl_q [DLY];

  // Fold each quadrant to 0..pi/4; above the octant the roles of sine and cosine swap.
  assign ph   = angle_i & PH_MASK;
  assign f    = ph[29:0];
  assign swap = f > 30'h2000_0000;
  assign g    = swap ? 30'(bmpg_pkg::ONE_Q30 - {1'b0, f}) : f;

  assign x_prod  = pg_q * bmpg_pkg::HALF_PI_Q31;
  assign x2_prod = x_q * x_q;

  always_comb begin
    si_x2[0] = x2_q;
    si_x[0]  = x2x_q;
    si_ts[0] = bmpg_pkg::ONE_Q30;
    si_tc[0] = bmpg_pkg::ONE_Q30;
    si_q[0]  = x2q_q;
    si_sw[0] = x2sw_q;
    for (int i = 1; i < NT; i++) begin
      si_x2[i] = dx2_q[i-1];
      si_x[i]  = dx_q[i-1];
      si_ts[i] = ts_q[i-1];
      si_tc[i] = tc_q[i-1];
      si_q[i]  = dq_q[i-1];
      si_sw[i] = dsw_q[i-1];
    end
    for (int i = 0; i < NT; i++) begin
      mps[i]   = si_x2[i] * si_ts[i];
      mpc[i]   = si_x2[i] * si_tc[i];
      qs[i]    = ms_q[i] * bmpg_pkg::SIN_RECIP[i][30:0];
      qc[i]    = mc_q[i] * bmpg_pkg::COS_RECIP[i][30:0];
      qs_sh[i] = qs[i] >> bmpg_pkg::SIN_SH[i];
      qc_sh[i] = qc[i] >> bmpg_pkg::COS_SH[i];
    end
  end

  assign sn_prod = dx_q[NT-1] * ts_q[NT-1];
  assign sn      = sn_prod[60:30];
  assign sn_sel  = dsw_q[NT-1] ? tc_q[NT-1] : sn;
  assign cs_sel  = dsw_q[NT-1] ? sn : tc_q[NT-1];

  always_comb begin
    unique case (fq_q)
      2'd0: quad_d = '{cmag: fc_q, cneg: 1'b0, smag: fs_q, sneg: 1'b0};
      2'd1: quad_d = '{cmag: fs_q, cneg: 1'b1, smag: fc_q, sneg: 1'b0};
      2'd2: quad_d = '{cmag: fc_q, cneg: 1'b1, smag: fs_q, sneg: 1'b1};
      default: quad_d = '{cmag: fs_q, cneg: 1'b0, smag: fc_q, sneg: 1'b1};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pq_q   <= ph[31:30];
      psw_q  <= swap;
      pg_q   <= g;
      x_q    <= x_prod[60:31];
      xq_q   <= pq_q;
      xsw_q  <= psw_q;
      x2_q   <= x2_prod[59:30];
      x2x_q  <= x_q;
      x2q_q  <= xq_q;
      x2sw_q <= xsw_q;
      for (int i = 0; i < NT; i++) begin
        ms_q[i]  <= mps[i][59:30];
        mc_q[i]  <= mpc[i][59:30];
        mx2_q[i] <= si_x2[i];
        mx_q[i]  <= si_x[i];
        mq_q[i]  <= si_q[i];
        msw_q[i] <= si_sw[i];
        ts_q[i]  <= bmpg_pkg::ONE_Q30 - {1'b0, qs_sh[i][29:0]};
        tc_q[i]  <= bmpg_pkg::ONE_Q30 - {1'b0, qc_sh[i][29:0]};
        dx2_q[i] <= mx2_q[i];
        dx_q[i]  <= mx_q[i];
        dq_q[i]  <= mq_q[i];
        dsw_q[i] <= msw_q[i];
      end
      fs_q <= sn_sel;
      fc_q <= cs_sel;
      fq_q <= dq_q[NT-1];
      dl_q[0] <= quad_d;
      for (int i = 1; i < DLY; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  assign trig_o = dl_q[DLY-1];

endmodule

@@ sv/bmpg_queue.sv @@
// Short FIFO of finished sample pairs between the arithmetic pipeline and the emitter.
module bmpg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bmpg_pkg::pair_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output bmpg_pkg::pair_t head_o
);

  localparam int unsigned DEPTH = bmpg_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  bmpg_pkg::pair_t mem_q [DEPTH];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ sv/bmpg_emit.sv @@
// Emitter: splits each queued pair into one or two result items, y before x, behind an output register.
module bmpg_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmpg_pkg::pair_t     head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmpg_pkg::out_item_t out_data_o
);

  logic                phase_q;
  logic                vld_q;
  bmpg_pkg::out_item_t out_q, out_d;
  logic                free, take, send_y;

  assign free   = !vld_q || !out_stall_i;
  assign take   = free && !empty_i;
  assign send_y = !phase_q && head_i.keep_y;
  assign pop_o  = take && !(send_y && head_i.keep_x);

  always_comb begin
    if (send_y) begin
      out_d.sample = head_i.y;
      out_d.last   = !head_i.keep_x;
    end else begin
      out_d.sample = head_i.x;
      out_d.last   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (free) begin
        vld_q <= !empty_i;
      end
      if (take) begin
        phase_q <= send_y && head_i.keep_x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/box_muller_positive_gaussian.sv @@
// Top level of the positive Gaussian sample generator: front pipeline, pair queue and emitter.
//
// Each input item is a pair of uniform words. The block forms a Box-Muller
// radius and angle, scales them by sigma, adds the mean, and emits every
// sample above min_value: y first, then x, with last set on the final one.
// A pair whose two samples are both rejected produces no result item.
// Both channels use valid and stall; an item moves on an edge where valid
// is high and stall is low. Configuration is a plain write port (index 0
// mean, 1 sigma, 2 min_value), to be written by the user only while the
// block is idle, a rule that the block itself leaves unenforced. The front is a 62-stage
// pipeline (radius path: normalize, 24 squaring steps of the log, a 27-stage
// square root; then four scaling stages) that takes one pair per cycle unless
// stalled. A four-entry queue of finished pairs decouples it from the emitter,
// whose output register gives one sample per cycle while the receiver does
// not stall, and a pair with two kept samples leaves the queue with its x sample.
// When the receiver stalls, the queue fills and the whole front pipeline
// freezes, raising in_stall_o. Reset empties the pipeline, queue and output
// register and loads mean 0, sigma 1.0 and min_value 2^-16.
module box_muller_positive_gaussian (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmpg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmpg_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned LAST = bmpg_pkg::PIPE_DEPTH - 1;

  logic [31:0] mean_q;
  logic [30:0] sigma_q;
  logic [30:0] min_q;

  logic [LAST:0] vld_q;
  logic          en;
  logic          keep_any;
  logic          q_full, q_empty, q_pop, q_push;

  logic [26:0]     root;
  bmpg_pkg::trig_t trig;

  // Scaling stages.
  logic [57:0]     mg_prod;
  logic [33:0]     mg_q;
  bmpg_pkg::trig_t ta_q;
  logic [47:0]     ylo_q, yhi_q, xlo_q, xhi_q;
  logic            syb_q, sxb_q;
  logic [64:0]     sum_y, sum_x;
  logic [33:0]     dy_q, dx_q;
  logic            syc_q, sxc_q;
  logic signed [35:0] mean_ext, vy, vx, min_ext;
  bmpg_pkg::pair_t pair_d, pair_q, head;

  function automatic logic [30:0] sat31(input logic signed [35:0] v);
    logic [30:0] r;
    if (v > 36'sd2147483647) begin
      r = 31'h7FFF_FFFF;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= 32'd0;
      sigma_q <= 31'd65536;
      min_q   <= 31'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmpg_pkg::REG_MEAN:  mean_q  <= cfg_data_i;
        bmpg_pkg::REG_SIGMA: sigma_q <= cfg_data_i[30:0];
        bmpg_pkg::REG_MIN:   min_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline only halts when its last stage holds a pair the queue cannot take.
  assign keep_any   = pair_q.keep_y || pair_q.keep_x;
  assign en         = !(vld_q[LAST] && keep_any && q_full);
  assign q_push     = vld_q[LAST] && keep_any && !q_full;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  bmpg_radius u_radius (
    .clk_i    (clk_i),
    .en_i     (en),
    .radius_i (in_data_i.uniform_radius),
    .root_o   (root)
  );

  bmpg_trig u_trig (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.uniform_angle),
    .trig_o  (trig)
  );

  // Magnitude sigma*r, then the two trig products split in halves of the magnitude.
  assign mg_prod  = sigma_q * root;
  assign sum_y    = {yhi_q, 17'd0} + 65'(ylo_q);
  assign sum_x    = {xhi_q, 17'd0} + 65'(xlo_q);
  assign mean_ext = $signed({{4{mean_q[31]}}, mean_q});
  assign min_ext  = $signed({5'd0, min_q});
  assign vy       = syc_q ? mean_ext - $signed({2'b00, dy_q}) : mean_ext + $signed({2'b00, dy_q});
  assign vx       = sxc_q ? mean_ext - $signed({2'b00, dx_q}) : mean_ext + $signed({2'b00, dx_q});

  always_comb begin
    pair_d.keep_y = vy > min_ext;
    pair_d.y      = sat31(vy);
    pair_d.keep_x = vx > min_ext;
    pair_d.x      = sat31(vx);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mg_q   <= mg_prod[57:24];
      ta_q   <= trig;
      ylo_q  <= mg_q[16:0] * ta_q.smag;
      yhi_q  <= mg_q[33:17] * ta_q.smag;
      xlo_q  <= mg_q[16:0] * ta_q.cmag;
      xhi_q  <= mg_q[33:17] * ta_q.cmag;
      syb_q  <= ta_q.sneg;
      sxb_q  <= ta_q.cneg;
      dy_q   <= sum_y[63:30];
      dx_q   <= sum_x[63:30];
      syc_q  <= syb_q;
      sxc_q  <= sxb_q;
      pair_q <= pair_d;
    end
  end

  bmpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (pair_q),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head)
  );

  bmpg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ dv/box_muller_positive_gaussian_tb.sv @@
// Self-checking testbench for the positive Gaussian sample generator.
`timescale 1ns / 1ps

module box_muller_positive_gaussian_tb;

  // Spare register index; writes to it must leave every register unchanged.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles to let the front pipeline empty out once nothing is expected.
  localparam int unsigned SETTLE_CYCLES = bmpg_pkg::PIPE_DEPTH + 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] ONE_Q30_W = 64'd1 << 30;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  bmpg_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  bmpg_pkg::out_item_t out_data_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  // Mirror of the block's registers, kept in step with every write.
  logic [31:0] mean_q;
  logic [30:0] sigma_q;
  logic [30:0] min_q;

  bmpg_pkg::out_item_t samples_due[$];
  int unsigned fail_count;
  bit sender_calm;
  bit receiver_calm;
  bit hold_req;

  box_muller_positive_gaussian dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // -log2(U / 2^UB) in Q8.24 by repeated squaring of the normalized mantissa.
  function automatic logic [63:0] neg_log2_q24(logic [31:0] u);
    int unsigned p;
    logic [63:0] m;
    logic [63:0] frac;
    p = 31;
    frac = '0;
    while (p > 0 && u[p] == 1'b0) p--;
    m = ({32'd0, u} << (31 - p)) & 64'hFFFF_FFFF;
    for (int i = 0; i < bmpg_pkg::LOG_FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(bmpg_pkg::UNIFORM_BITS) << bmpg_pkg::LOG_FRAC_BITS) -
           ((64'(p) << bmpg_pkg::LOG_FRAC_BITS) + frac);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Truncated Taylor series in Horner form; odd selects the sine divisors.
  function automatic logic [63:0] taylor_q30(logic [63:0] x2, bit odd);
    logic [63:0] t;
    logic [63:0] div;
    t = ONE_Q30_W;
    for (int k = 5; k >= 1; k--) begin
      div = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
      t = ONE_Q30_W - ((x2 * t) >> 30) / div;
    end
    return t;
  endfunction

  // Works out the samples one uniform pair must yield and queues them.
  function automatic void predict_samples(bmpg_pkg::in_item_t it);
    int unsigned drop;
    logic [31:0] u;
    logic [63:0] ph, r, f, g, x, x2, sn, cs, tmp, mg, cmag, smag;
    logic [63:0] mags[2];
    bit negs[2];
    bit cneg, sneg, swap;
    logic [1:0] quad;
    longint mval, v;
    bmpg_pkg::out_item_t kept[$];
    bmpg_pkg::out_item_t o;
    drop = 32 - bmpg_pkg::UNIFORM_BITS;
    u = it.uniform_radius >> drop;
    ph = {32'd0, (it.uniform_angle >> drop) << drop};
    // A zero radius word stands for one LSB, which saturates the radius.
    if (u == 0) u = 32'd1;
    r = isqrt64(((neg_log2_q24(u) * 64'(bmpg_pkg::TWO_LN2_Q30)) >> 30) << 24);
    quad = ph[31:30];
    f = ph & (ONE_Q30_W - 1);
    swap = f > (ONE_Q30_W >> 1);
    g = swap ? ONE_Q30_W - f : f;
    x = (g * 64'(bmpg_pkg::HALF_PI_Q31)) >> 31;
    x2 = (x * x) >> 30;
    sn = (x * taylor_q30(x2, 1'b1)) >> 30;
    cs = taylor_q30(x2, 1'b0);
    if (swap) begin
      tmp = sn;
      sn = cs;
      cs = tmp;
    end
    case (quad)
      2'd0: begin cmag = cs; cneg = 0; smag = sn; sneg = 0; end
      2'd1: begin cmag = sn; cneg = 1; smag = cs; sneg = 0; end
      2'd2: begin cmag = cs; cneg = 1; smag = sn; sneg = 1; end
      default: begin cmag = sn; cneg = 0; smag = cs; sneg = 1; end
    endcase
    mg = (64'(sigma_q) * r) >> 24;
    mval = longint'($signed(mean_q));
    mags[0] = (mg * smag) >> 30;
    negs[0] = sneg;
    mags[1] = (mg * cmag) >> 30;
    negs[1] = cneg;
    for (int i = 0; i < 2; i++) begin
      v = negs[i] ? mval - longint'(mags[i]) : mval + longint'(mags[i]);
      if (v > longint'(min_q)) begin
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        o.sample = v[30:0];
        o.last = 1'b0;
        kept = {kept, o};
      end
    end
    if (kept.size() > 0) kept[kept.size() - 1].last = 1'b1;
    samples_due = {samples_due, kept};
  endfunction

  // Offers one pair, idling at random first, and predicts it once taken.
  task automatic send_pair(bmpg_pkg::in_item_t it);
    while (!sender_calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_samples(it);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bmpg_pkg::REG_MEAN: mean_q = value;
      bmpg_pkg::REG_SIGMA: sigma_q = value[30:0];
      bmpg_pkg::REG_MIN: min_q = value[30:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Sender pauses until every sample has come out and the pipeline is empty.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic bmpg_pkg::in_item_t random_pair();
    bmpg_pkg::in_item_t it;
    it.uniform_radius = $urandom();
    it.uniform_angle = $urandom();
    // Small radius words reach the long tail where samples saturate.
    case ($urandom_range(9))
      0: it.uniform_radius = $urandom_range(15);
      1: it.uniform_radius = it.uniform_radius >> $urandom_range(31);
      default: ;
    endcase
    return it;
  endfunction

  task automatic test_directed;
    logic [31:0] radii[5];
    logic [31:0] angles[5];
    radii = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    angles = '{32'd0, 32'h4000_0000, 32'h2000_0000, 32'h2000_0001, 32'hFFFF_FFFF};
    // Quadrants 0, 1 and 3 plus the swap boundary, each radius paired with two of the angles.
    foreach (radii[i]) begin
      send_pair('{uniform_radius: radii[i], uniform_angle: angles[i]});
      send_pair('{uniform_radius: radii[i], uniform_angle: angles[(i + 2) % 5]});
    end
    send_pair('{uniform_radius: 32'h4000_0000, uniform_angle: 32'h8000_0000});
    send_pair('{uniform_radius: 32'h4000_0000, uniform_angle: 32'hC000_0000});
    send_pair('{uniform_radius: 32'h0000_0003, uniform_angle: 32'h6000_0000});
    send_pair('{uniform_radius: 32'h7FFF_FFFF, uniform_angle: 32'hA000_0000});
    send_pair('{uniform_radius: 32'h0000_0002, uniform_angle: 32'hE000_0000});
  endtask

  task automatic test_random(int unsigned count, int unsigned calm_count);
    for (int unsigned i = 0; i < count; i++) begin
      sender_calm = (i < calm_count);
      receiver_calm = (i < calm_count);
      send_pair(random_pair());
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  // The receiver holds off while pairs keep coming, so the pipeline fills and stalls.
  task automatic test_backpressure;
    hold_req <= 1'b1;
    sender_calm = 1'b1;
    for (int i = 0; i < 100; i++) send_pair(random_pair());
    sender_calm = 1'b0;
    drain();
  endtask

  task automatic test_settings;
    drain();
    write_reg(bmpg_pkg::REG_MEAN, 32'h0005_0000);
    write_reg(bmpg_pkg::REG_SIGMA, 32'h0000_4000);
    write_reg(bmpg_pkg::REG_MIN, 32'd0);
    test_random(70, 0);
    drain();
    // Extremes: most negative mean, largest sigma and threshold, high bits masked.
    write_reg(bmpg_pkg::REG_MEAN, 32'h8000_0000);
    write_reg(bmpg_pkg::REG_SIGMA, 32'hFFFF_FFFF);
    write_reg(bmpg_pkg::REG_MIN, 32'hFFFF_FFFF);
    test_random(70, 0);
    drain();
    write_reg(bmpg_pkg::REG_MEAN, 32'h7FFF_FFFF);
    write_reg(bmpg_pkg::REG_SIGMA, 32'd0);
    write_reg(bmpg_pkg::REG_MIN, 32'h7FFF_FFFE);
    test_random(40, 0);
    drain();
    write_reg(REG_SPARE, $urandom());
    write_reg(bmpg_pkg::REG_MEAN, 32'hFFFE_0000);
    write_reg(bmpg_pkg::REG_SIGMA, 32'h0003_0000);
    write_reg(bmpg_pkg::REG_MIN, 32'h0000_8000);
    test_random(70, 0);
    drain();
    write_reg(bmpg_pkg::REG_MEAN, $urandom());
    write_reg(bmpg_pkg::REG_SIGMA, $urandom_range(32'h0010_0000));
    write_reg(bmpg_pkg::REG_MIN, $urandom_range(32'h0002_0000));
    test_random(70, 0);
    drain();
  endtask

  // Receiver: random stalls, calm stretches, and one long requested hold.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= receiver_calm ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  // Compares each sample leaving the block with the oldest one expected.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (samples_due.size() == 0) begin
        $error("unexpected sample %0d", out_data_o.sample);
        fail_count++;
      end else begin
        if (out_data_o.sample !== samples_due[0].sample) begin
          $error("sample: expected %0d, got %0d", samples_due[0].sample, out_data_o.sample);
          fail_count++;
        end
        if (out_data_o.last !== samples_due[0].last) begin
          $error("last: expected %0d, got %0d", samples_due[0].last, out_data_o.last);
          fail_count++;
        end
        void'(samples_due.pop_front());
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= bmpg_pkg::REG_MEAN;
    cfg_data_i <= '0;
    mean_q = '0;
    sigma_q = 31'd65536;
    min_q = 31'd1;
    fail_count = 0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120, 40);
    test_backpressure();
    test_settings();
    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
sv/bmpg_pkg.sv
sv/bmpg_radius.sv
sv/bmpg_trig.sv
sv/bmpg_queue.sv
sv/bmpg_emit.sv
sv/box_muller_positive_gaussian.sv
dv/box_muller_positive_gaussian_tb.sv
